[rtl/triangle_unit_normal_macros.svh]
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Concurrent assertion wrappers on clk with the synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TUN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("triangle_unit_normal assertion failed");
// Next-cycle implication, checked out of reset.
`define TUN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("triangle_unit_normal assertion failed");
`else
`define TUN_ASSERT_IMP(label, ante, cons)
`define TUN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/tun_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, stage types and shared constants of the facet normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int COORD_WIDTH      = 32;
  localparam int NORMAL_FRAC_BITS = 30;

  localparam int OUT_W     = 32;
  localparam int EDGE_W    = COORD_WIDTH + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = CROSS_W - 1;
  localparam int POS_W     = $clog2(MAG_W);
  localparam int NORM_W    = 31;
  localparam int NORM_TOP  = NORM_W - 1;
  localparam int SQ_W      = 2 * NORM_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = NORM_W + 1;
  localparam int REM_W     = ROOT_W + 3;
  localparam int DIV_STEPS = NORMAL_FRAC_BITS + 1;
  localparam int NUM_W     = NORM_W + DIV_STEPS;
  localparam int PRE_STAGES = 8;
  localparam int VLEN      = PRE_STAGES + ROOT_W + DIV_STEPS;

  typedef logic [NORM_W-1:0] norm_t;
  typedef logic [2:0][NORM_W-1:0] norm3_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  x;
  } sq_stage_t;

  typedef struct packed {
    logic [ROOT_W-1:0]    r;
    logic [ROOT_W-1:0]    d;
    logic [DIV_STEPS-1:0] n;
    logic [DIV_STEPS-1:0] q;
  } dv_stage_t;

endpackage

`default_nettype wire

[rtl/tun_ifs.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal channels
// Valid/ready channels for triangles in and unit normals out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tun_in_if import tun_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  ax, ay, az;
  logic signed [COORD_WIDTH-1:0]  bx, by, bz;
  logic signed [COORD_WIDTH-1:0]  cx, cy, cz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  nx, ny, nz;
  logic                     degenerate;

  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface

`default_nettype wire

[rtl/tun_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; floor of the square root of a 64-bit sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_isqrt import tun_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  x,
  output logic [ROOT_W-1:0] root
);

  sq_stage_t st_r   [ROOT_W];
  sq_stage_t st_nxt [ROOT_W];
  sq_stage_t init;

  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t        o;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] trial;
    rem   = {s.rem[REM_W-3:0], s.x[SUM_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    o.x   = s.x << 2;
    if (rem >= trial) begin
      o.rem  = rem - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.x    = x;
    st_nxt[0] = sq_step(init);
    for (int k = 1; k < ROOT_W; k++) begin
      st_nxt[k] = sq_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign root = st_r[ROOT_W-1].root;

endmodule

`default_nettype wire

[rtl/tun_div.sv]
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Computes (m * 2^F + len/2) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div import tun_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NORM_W-1:0]    m,
  input  logic [ROOT_W-1:0]    len,
  output logic [DIV_STEPS-1:0] q
);

  dv_stage_t        st_r   [DIV_STEPS];
  dv_stage_t        st_nxt [DIV_STEPS];
  dv_stage_t        init;
  logic [NUM_W-1:0] num;

  function automatic dv_stage_t dv_step(input dv_stage_t s);
    dv_stage_t         o;
    logic [ROOT_W:0]   t;
    logic [ROOT_W:0]   dd;
    t   = {s.r, s.n[DIV_STEPS-1]};
    dd  = {1'b0, s.d};
    o.d = s.d;
    o.n = s.n << 1;
    if (t >= dd) begin
      o.r = ROOT_W'(t - dd);
      o.q = {s.q[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.r = t[ROOT_W-1:0];
      o.q = {s.q[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    // The quotient never exceeds 2^F, so the top part of the numerator is below len.
    num       = (NUM_W'(m) << NORMAL_FRAC_BITS) + NUM_W'(len >> 1);
    init.r    = ROOT_W'(num[NUM_W-1:DIV_STEPS]);
    init.d    = len;
    init.n    = num[DIV_STEPS-1:0];
    init.q    = '0;
    st_nxt[0] = dv_step(init);
    for (int k = 1; k < DIV_STEPS; k++) begin
      st_nxt[k] = dv_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign q = st_r[DIV_STEPS-1].q;

endmodule

`default_nettype wire

[rtl/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal
// Unit facet normal of a Q16.16 triangle in Q1.30, fully pipelined.
// ----------------------------------------------------------------------------
// Structure: 8 front stages, 32 square root stages, 31 divider stages and the
//   output register.
// Throughput: one item per cycle; the whole pipeline advances when the output
//   register is empty or being taken, and otherwise holds every stage.
// Reset: synchronous, active low; it clears the valid bits only.
`default_nettype none
`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal import tun_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tun_in_if.sink     in_ch,
  tun_out_if.source  out_ch
);

  // Global advance: every stage moves together, so a stall freezes items in
  // place and nothing is lost or repeated.
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Valid bits, one per stage, travelling with the data.
  logic [VLEN-1:0] vline_r;
  logic [VLEN-1:0] vline_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;

  // Stage 1: edge vectors B - A and C - A, exact.
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [EDGE_W-1:0] e1_nxt [3];
  logic signed [EDGE_W-1:0] e2_nxt [3];

  // Stage 2: the six partial products of the cross product.
  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [PROD_W-1:0] prod_nxt [6];

  // Stage 3: cross product components, exact.
  logic signed [CROSS_W-1:0] cross_r [3];
  logic signed [CROSS_W-1:0] cross_nxt [3];

  // Stage 4: magnitudes and signs.
  logic [MAG_W-1:0] mag_r [3];
  logic [MAG_W-1:0] mag_nxt [3];
  logic [2:0]       neg4_r;
  logic [2:0]       neg4_nxt;

  // Stage 5: leading one position over all three magnitudes.
  logic [MAG_W-1:0] mag5_r [3];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [MAG_W-1:0] orv;
  side_t            side5_r;
  side_t            side5_nxt;

  // Stage 6: normalized magnitudes, largest in [2^30, 2^31).
  norm3_t           m6_r;
  norm3_t           m6_nxt;
  logic [MAG_W-1:0] shifted [3];
  side_t            side6_r;

  // Stage 7: squares. Stage 8: sum of squares.
  logic [SQ_W-1:0]  sq_r [3];
  logic [SQ_W-1:0]  sq_nxt [3];
  norm3_t           m7_r;
  side_t            side7_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  norm3_t           m8_r;
  side_t            side8_r;

  // Delay lines that keep the magnitudes and signs next to the root and quotient.
  norm3_t mline_r [ROOT_W];
  side_t  sline_r [ROOT_W + DIV_STEPS];

  logic [ROOT_W-1:0]    len;
  logic [DIV_STEPS-1:0] quo [3];

  // Output register.
  logic signed [OUT_W-1:0] n_r [3];
  logic signed [OUT_W-1:0] n_nxt [3];
  logic                    deg_r;
  logic                    deg_nxt;

  always_comb begin
    e1_nxt[0] = EDGE_W'(in_ch.bx) - EDGE_W'(in_ch.ax);
    e1_nxt[1] = EDGE_W'(in_ch.by) - EDGE_W'(in_ch.ay);
    e1_nxt[2] = EDGE_W'(in_ch.bz) - EDGE_W'(in_ch.az);
    e2_nxt[0] = EDGE_W'(in_ch.cx) - EDGE_W'(in_ch.ax);
    e2_nxt[1] = EDGE_W'(in_ch.cy) - EDGE_W'(in_ch.ay);
    e2_nxt[2] = EDGE_W'(in_ch.cz) - EDGE_W'(in_ch.az);
  end

  always_comb begin
    prod_nxt[0] = PROD_W'(e1_r[1]) * PROD_W'(e2_r[2]);
    prod_nxt[1] = PROD_W'(e1_r[2]) * PROD_W'(e2_r[1]);
    prod_nxt[2] = PROD_W'(e1_r[2]) * PROD_W'(e2_r[0]);
    prod_nxt[3] = PROD_W'(e1_r[0]) * PROD_W'(e2_r[2]);
    prod_nxt[4] = PROD_W'(e1_r[0]) * PROD_W'(e2_r[1]);
    prod_nxt[5] = PROD_W'(e1_r[1]) * PROD_W'(e2_r[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_nxt[i] = CROSS_W'(prod_r[2*i]) - CROSS_W'(prod_r[2*i+1]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg4_nxt[i] = cross_r[i][CROSS_W-1];
      mag_nxt[i]  = neg4_nxt[i] ? MAG_W'(-cross_r[i]) : MAG_W'(cross_r[i]);
    end
  end

  // Priority encoder for the highest set bit; an all-zero vector flags the
  // degenerate case, where the position is don't-care.
  always_comb begin
    orv     = mag_r[0] | mag_r[1] | mag_r[2];
    pos_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) begin
        pos_nxt = POS_W'(i);
      end
    end
    side5_nxt.neg = neg4_r;
    side5_nxt.deg = (orv == '0);
  end

  // Shift right with truncation when the leading one sits above bit 30,
  // otherwise shift left, so the largest magnitude lands in [2^30, 2^31).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_r > POS_W'(NORM_TOP)) begin
        shifted[i] = mag5_r[i] >> (pos_r - POS_W'(NORM_TOP));
      end else begin
        shifted[i] = mag5_r[i] << (POS_W'(NORM_TOP) - pos_r);
      end
      m6_nxt[i] = shifted[i][NORM_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = SQ_W'(m6_r[i]) * SQ_W'(m6_r[i]);
    end
    sum_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  tun_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .x    (sum_r),
    .root (len)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    tun_div u_div (
      .clk (clk),
      .en  (adv),
      .m   (mline_r[ROOT_W-1][g]),
      .len (len),
      .q   (quo[g])
    );
  end

  // Sign is restored after the unsigned divide; a zero cross product forces
  // the normal to zero, since its length is zero and the quotient is meaningless.
  always_comb begin
    deg_nxt = sline_r[ROOT_W+DIV_STEPS-1].deg;
    for (int i = 0; i < 3; i++) begin
      if (deg_nxt) begin
        n_nxt[i] = '0;
      end else if (sline_r[ROOT_W+DIV_STEPS-1].neg[i]) begin
        n_nxt[i] = -$signed(OUT_W'(quo[i]));
      end else begin
        n_nxt[i] = $signed(OUT_W'(quo[i]));
      end
    end
  end

  always_comb begin
    vline_nxt     = {vline_r[VLEN-2:0], in_ch.valid};
    out_valid_nxt = vline_r[VLEN-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vline_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vline_r     <= vline_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r    <= e1_nxt;
      e2_r    <= e2_nxt;
      prod_r  <= prod_nxt;
      cross_r <= cross_nxt;
      mag_r   <= mag_nxt;
      neg4_r  <= neg4_nxt;
      mag5_r  <= mag_r;
      pos_r   <= pos_nxt;
      side5_r <= side5_nxt;
      m6_r    <= m6_nxt;
      side6_r <= side5_r;
      sq_r    <= sq_nxt;
      m7_r    <= m6_r;
      side7_r <= side6_r;
      sum_r   <= sum_nxt;
      m8_r    <= m7_r;
      side8_r <= side7_r;
      mline_r[0] <= m8_r;
      for (int k = 1; k < ROOT_W; k++) begin
        mline_r[k] <= mline_r[k-1];
      end
      sline_r[0] <= side8_r;
      for (int k = 1; k < ROOT_W + DIV_STEPS; k++) begin
        sline_r[k] <= sline_r[k-1];
      end
      n_r   <= n_nxt;
      deg_r <= deg_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.nx         = n_r[0];
  assign out_ch.ny         = n_r[1];
  assign out_ch.nz         = n_r[2];
  assign out_ch.degenerate = deg_r;

  // A degenerate triangle must come out as an all-zero normal.
  `TUN_ASSERT_IMP(a_deg_zero, out_valid_r && deg_r, n_r[0] == 0 && n_r[1] == 0 && n_r[2] == 0)
  // When the output stalls, no valid bit may move inside the pipeline.
  `TUN_ASSERT_NEXT(a_stall_hold, !adv, $stable(vline_r))
  // An accepted item occupies the first stage on the next cycle.
  `TUN_ASSERT_NEXT(a_enter, in_ch.valid && in_ch.ready, vline_r[0])

endmodule

`default_nettype wire

[sim/triangle_unit_normal_tb.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles through the facet normal pipeline under random idling on
// both channels and checks every normal against a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_unit_normal_tb;
  import tun_pkg::*;

  typedef struct {
    logic signed [31:0] v [9];
  } tri_t;

  typedef struct {
    logic [31:0] nx, ny, nz;
    logic        deg;
  } normal_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tun_in_if  in_ch ();
  tun_out_if out_ch ();

  triangle_unit_normal i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #2 clk = ~clk;

  tri_t    pending_tris [$];
  normal_t expected_normals [$];
  int      send_idle_pct = 13;
  int      recv_idle_pct = 53;
  int      hold_left = 0;
  int      mismatches = 0;
  int      checked = 0;
  int      degenerate_seen = 0;
  int      quiet_cycles = 0;
  bit      stim_done = 1'b0;
  bit      in_taken = 1'b0;

  // Bit-exact prediction of one facet normal. Edges and the cross product are
  // exact at 130 bits, which holds every possible component without overflow.
  function automatic normal_t predict_normal(tri_t t);
    logic signed [129:0] a [9];
    logic signed [129:0] e1 [3];
    logic signed [129:0] e2 [3];
    logic signed [129:0] cr [3];
    logic [129:0] mag [3];
    logic [129:0] orv;
    logic [129:0] sh;
    logic [63:0]  m [3];
    logic [63:0]  sum, len, rem, bitv, q;
    logic [127:0] num;
    logic [31:0]  comp [3];
    int p;
    normal_t r;
    for (int i = 0; i < 9; i++) a[i] = t.v[i];
    for (int i = 0; i < 3; i++) begin
      e1[i] = a[3+i] - a[i];
      e2[i] = a[6+i] - a[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i][129] ? -cr[i] : cr[i];
      orv |= mag[i];
    end
    r.deg = (orv == '0);
    if (r.deg) begin
      r.nx = '0; r.ny = '0; r.nz = '0;
      return r;
    end
    p = 0;
    for (int b = 0; b < 130; b++) if (orv[b]) p = b;
    for (int i = 0; i < 3; i++) begin
      sh = (p > 30) ? (mag[i] >> (p - 30)) : (mag[i] << (30 - p));
      m[i] = sh[63:0];
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    // Digit-by-digit integer square root.
    rem = sum; len = '0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem = rem - (len + bitv);
        len = (len >> 1) + bitv;
      end else begin
        len = len >> 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      num = ({64'd0, m[i]} << NORMAL_FRAC_BITS) + (len >> 1);
      q = 64'(num / len);
      comp[i] = cr[i][129] ? (32'd0 - q[31:0]) : q[31:0];
    end
    r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
    return r;
  endfunction

  // Random coordinate: mostly small meshes, sometimes full range or extremes.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2:    return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3:    return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  task automatic add_tri(input logic signed [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8);
    tri_t t;
    t.v = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    pending_tris.push_back(t);
  endtask

  // Ready can change between the rising and the falling edge, so the driver
  // relies on what happened at the rising edge itself.
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // Driver: offers the oldest pending item, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_tris.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        tri_t t;
        t = pending_tris.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.ax, in_ch.ay, in_ch.az} <= {t.v[0], t.v[1], t.v[2]};
        {in_ch.bx, in_ch.by, in_ch.bz} <= {t.v[3], t.v[4], t.v[5]};
        {in_ch.cx, in_ch.cy, in_ch.cz} <= {t.v[6], t.v[7], t.v[8]};
        expected_normals.push_back(predict_normal(t));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with a long hold-off counted here when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each accepted normal with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        normal_t e;
        if (expected_normals.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected normal item at %0t", $realtime);
        end else begin
          e = expected_normals.pop_front();
          checked <= checked + 1;
          if (e.deg) degenerate_seen <= degenerate_seen + 1;
          if (out_ch.nx !== e.nx || out_ch.ny !== e.ny || out_ch.nz !== e.nz ||
              out_ch.degenerate !== e.deg) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp %h %h %h %b got %h %h %h %b", e.nx, e.ny, e.nz,
                       e.deg, out_ch.nx, out_ch.ny, out_ch.nz, out_ch.degenerate);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d items outstanding", expected_normals.size());
        $display("triangle_unit_normal_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_tris.size() != 0 || in_ch.valid || expected_normals.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz} = '0;
    {in_ch.cx, in_ch.cy, in_ch.cz} = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: axis-aligned facets, both windings, all-coincident and collinear
    // vertices, and corners of the coordinate range.
    add_tri(0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0);
    add_tri(0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0);
    add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5);
    add_tri(0, 0, 0, 1, 2, 3, 2, 4, 6);
    add_tri(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    add_tri(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
            32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    add_tri(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    add_tri(0, 0, 0, 1, 1, 1, 1, 1, 2);
    add_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1);
    add_tri(0, 0, 0, 1, 0, 0, 0, 32'sh7fffffff, 0);
    add_tri(32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'hffffffff,
            32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'hffffffff);

    // Random phases: sender-light idling, then receiver-light, then none.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 13 : 0;
      for (int n = 0; n < 580; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          // Collinear: C = A + k*(B - A).
          logic signed [31:0] a0, a1, a2;
          int k;
          a0 = $signed($urandom_range(0, 65535)) - 32768;
          a1 = $signed($urandom_range(0, 65535)) - 32768;
          a2 = $signed($urandom_range(0, 65535)) - 32768;
          k = $urandom_range(0, 3);
          add_tri(a0, a1, a2, a0 + 7, a1 - 3, a2 + 11, a0 + 7 * k, a1 - 3 * k, a2 + 11 * k);
        end else begin
          add_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
      end
      // Long receiver hold-off while the sender keeps offering items.
      if (ph == 2) hold_left = HOLD_CYCLES;
      wait_drained();
    end
    stim_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d normals, %0d degenerate, over three idling profiles",
             checked, degenerate_seen);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("triangle_unit_normal_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("triangle_unit_normal_tb: FAIL");
    end
    $finish;
  end

endmodule
